/* hdl/lfdc_pkg.sv */
`default_nettype none

package lfdc_pkg;

	localparam int SMP_W      = 10;
	localparam int REC_W      = 8;
	localparam int GAIN_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;
	localparam int FRAC_W     = 16;
	localparam int MAG_W      = 15;
	localparam int MUL_W      = 24;
	localparam int MUL_OUT_W  = 16;
	localparam int PWM_W      = 8;

	// Q2.14 constants
	localparam logic [MAG_W-1:0] ONE_Q14        = 15'd16384;
	localparam logic [MAG_W-1:0] NEAR_SCALE_Q14 = 15'd15565;
	localparam logic signed [FRAC_W-1:0] FRAC_ONE     = 16'sd16384;
	localparam logic signed [FRAC_W-1:0] FRAC_TURN    = 16'sd14746;
	localparam logic signed [FRAC_W-1:0] FRAC_NEG_ONE = -16'sd16384;

	// ceil(2^30 / 125): x * 4096 / 125 is exact as (x * 4096 * RECIP_125) >> 30
	localparam logic [MUL_W-1:0] RECIP_125 = 24'd8589935;

	localparam logic [SMP_W-1:0]  LOST_SAT = 10'd1023;

	localparam logic [SMP_W-1:0]  RST_LINE_THRESHOLD    = 10'd300;
	localparam logic [SMP_W-1:0]  RST_NEAR_DISTANCE     = 10'd950;
	localparam logic [SMP_W-1:0]  RST_CRITICAL_DISTANCE = 10'd200;
	localparam logic [SMP_W-1:0]  RST_CLAP_LOW          = 10'd100;
	localparam logic [SMP_W-1:0]  RST_CLAP_HIGH         = 10'd400;
	localparam logic [REC_W-1:0]  RST_RECOVERY_LENGTH   = 8'd50;
	localparam logic [GAIN_W-1:0] RST_GAIN_LEFT         = 8'd255;
	localparam logic [GAIN_W-1:0] RST_GAIN_RIGHT        = 8'd251;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_STEER,
		ST_FACT,
		ST_MAGL,
		ST_PWML,
		ST_MAGR,
		ST_PWMR,
		ST_LAST,
		ST_OUT
	} state_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_THRESHOLD    = 3'd0,
		REG_NEAR_DISTANCE     = 3'd1,
		REG_CRITICAL_DISTANCE = 3'd2,
		REG_CLAP_LOW          = 3'd3,
		REG_CLAP_HIGH         = 3'd4,
		REG_RECOVERY_LENGTH   = 3'd5,
		REG_GAIN_LEFT         = 3'd6,
		REG_GAIN_RIGHT        = 3'd7
	} cfg_reg_t;

	typedef enum logic {
		SH_14,
		SH_30
	} shift_t;

	typedef struct packed {
		logic [MUL_W-1:0] opa;
		logic [MUL_W-1:0] opb;
		shift_t           sh;
	} mul_req_t;

endpackage

`default_nettype wire

/* hdl/lfdc_mul.sv */
`default_nettype none

module lfdc_mul (
	input  logic                             clk,
	input  logic                             en,
	input  lfdc_pkg::mul_req_t               req,
	output logic [lfdc_pkg::MUL_OUT_W-1:0]   prod
);
	import lfdc_pkg::*;

	logic [2*MUL_W-1:0]   full;
	logic [2*MUL_W-1:0]   shifted;
	logic [MUL_OUT_W-1:0] prod_q;

	assign full = req.opa * req.opb;

	always_comb begin
		unique case (req.sh)
			SH_14:   shifted = full >> 14;
			SH_30:   shifted = full >> 30;
			default: shifted = full;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= shifted[MUL_OUT_W-1:0];
		end
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

/* hdl/line_follow_drive_controller.sv */
// a moving beat passes through STEER, FACT, MAGL, PWML, MAGR, PWMR and LAST to OUT;
// idle or halted beats go straight to OUT; new beats are taken only in IDLE; one shared
// multiplier runs six products in turn (steer, distance scale, magnitude and pwm per motor)
// the input side accepts again while a finished result waits to be taken
// arst_n clears control state and loads the register defaults; the bot waits for a clap
`default_nettype none

module line_follow_drive_controller #(
	parameter int LOST_LIMIT = 700
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [lfdc_pkg::SMP_W-1:0]        sound_level,
	input  logic [lfdc_pkg::SMP_W-1:0]        line_left_level,
	input  logic [lfdc_pkg::SMP_W-1:0]        line_right_level,
	input  logic [lfdc_pkg::SMP_W-1:0]        front_distance,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              left_forward,
	output logic [lfdc_pkg::PWM_W-1:0]        left_pwm,
	output logic                              right_forward,
	output logic [lfdc_pkg::PWM_W-1:0]        right_pwm,
	output logic                              blue_lamp,
	output logic                              green_lamp,
	output logic                              red_lamp,
	output logic                              running,
	output logic                              stopped_lost,
	input  logic                              cfg_we,
	input  logic [lfdc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lfdc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import lfdc_pkg::*;

	localparam logic [SMP_W-1:0] LOST_LIMIT_V = SMP_W'(LOST_LIMIT);

	// configuration
	logic [SMP_W-1:0]  line_threshold_q, near_distance_q, critical_distance_q;
	logic [SMP_W-1:0]  clap_low_q, clap_high_q;
	logic [REC_W-1:0]  recovery_length_q;
	logic [GAIN_W-1:0] gain_left_q, gain_right_q;

	// controller state
	logic              moving_q, halted_q, lost_on_left_q, blue_q, green_q;
	logic [REC_W-1:0]  recovery_q;
	logic [SMP_W-1:0]  lost_q;
	logic [MAG_W-1:0]  factor_q;

	// per-beat working registers
	state_t                    state_q, state_nxt;
	logic [SMP_W-1:0]          dist_q;
	logic [SMP_W-1:0]          absdiff_q;
	logic                      steer_q, diff_neg_q;
	logic signed [FRAC_W-1:0]  ml_q, mr_q;
	logic                      fwd_l_q, fwd_r_q;
	logic [PWM_W-1:0]          pwm_l_q, pwm_r_q;

	// result register
	logic              out_valid_q;
	logic              out_fwd_l_q, out_fwd_r_q, out_blue_q, out_green_q, out_red_q;
	logic              out_run_q, out_stop_q;
	logic [PWM_W-1:0]  out_pwm_l_q, out_pwm_r_q;

	logic                     accept, out_load, go_motion, lost_over, clap;
	logic                     lb, rb;
	logic [MUL_OUT_W-1:0]     mul_prod;
	mul_req_t                 mul_req;
	logic                     mul_en;
	logic signed [FRAC_W+1:0] steer_frac;
	logic signed [FRAC_W-1:0] steer_clamped;
	logic signed [FRAC_W-1:0] neg_ml, neg_mr;
	logic [MAG_W-1:0]         abs_ml, abs_mr, factor_new;

	assign accept    = in_valid && !in_stall;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || !out_stall);
	assign lost_over = lost_q > LOST_LIMIT_V;
	assign go_motion = !halted_q && moving_q && !lost_over;
	assign clap      = (sound_level <= clap_low_q) || (sound_level >= clap_high_q);
	assign lb        = line_left_level < line_threshold_q;
	assign rb        = line_right_level < line_threshold_q;

	// 16384 - steer, clamped at -1.0
	assign steer_frac    = 18'sd16384 - $signed({2'b00, mul_prod});
	assign steer_clamped = (steer_frac < -18'sd16384) ? FRAC_NEG_ONE
	                                                  : steer_frac[FRAC_W-1:0];

	assign neg_ml = -ml_q;
	assign neg_mr = -mr_q;
	assign abs_ml = ml_q[FRAC_W-1] ? neg_ml[MAG_W-1:0] : ml_q[MAG_W-1:0];
	assign abs_mr = mr_q[FRAC_W-1] ? neg_mr[MAG_W-1:0] : mr_q[MAG_W-1:0];

	always_comb begin
		if (dist_q <= critical_distance_q) begin
			factor_new = '0;
		end else if (dist_q <= near_distance_q) begin
			factor_new = mul_prod[MAG_W-1:0];
		end else begin
			factor_new = ONE_Q14;
		end
	end

	lfdc_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.req  (mul_req),
		.prod (mul_prod)
	);

	// sequencer: next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_nxt = go_motion ? ST_STEER : ST_OUT;
			ST_STEER: state_nxt = ST_FACT;
			ST_FACT:  state_nxt = ST_MAGL;
			ST_MAGL:  state_nxt = ST_PWML;
			ST_PWML:  state_nxt = ST_MAGR;
			ST_MAGR:  state_nxt = ST_PWMR;
			ST_PWMR:  state_nxt = ST_LAST;
			ST_LAST:  state_nxt = ST_OUT;
			ST_OUT:   if (!out_valid_q || !out_stall) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// sequencer: outputs, multiplier operands
	always_comb begin
		in_stall    = 1'b1;
		mul_en      = 1'b0;
		mul_req.opa = '0;
		mul_req.opb = '0;
		mul_req.sh  = SH_14;
		unique case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_STEER: begin
				mul_en      = 1'b1;
				mul_req.opa = {2'b00, absdiff_q, 12'b0};
				mul_req.opb = RECIP_125;
				mul_req.sh  = SH_30;
			end
			ST_FACT: begin
				mul_en      = 1'b1;
				mul_req.opa = {9'b0, factor_q};
				mul_req.opb = {9'b0, NEAR_SCALE_Q14};
			end
			ST_MAGL: begin
				mul_en      = 1'b1;
				mul_req.opa = {9'b0, abs_ml};
				mul_req.opb = {9'b0, factor_new};
			end
			ST_PWML: begin
				mul_en      = 1'b1;
				mul_req.opa = {16'b0, gain_left_q};
				mul_req.opb = {8'b0, mul_prod};
			end
			ST_MAGR: begin
				mul_en      = 1'b1;
				mul_req.opa = {9'b0, abs_mr};
				mul_req.opb = {9'b0, factor_q};
			end
			ST_PWMR: begin
				mul_en      = 1'b1;
				mul_req.opa = {16'b0, gain_right_q};
				mul_req.opb = {8'b0, mul_prod};
			end
			ST_LAST, ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_threshold_q    <= RST_LINE_THRESHOLD;
			near_distance_q     <= RST_NEAR_DISTANCE;
			critical_distance_q <= RST_CRITICAL_DISTANCE;
			clap_low_q          <= RST_CLAP_LOW;
			clap_high_q         <= RST_CLAP_HIGH;
			recovery_length_q   <= RST_RECOVERY_LENGTH;
			gain_left_q         <= RST_GAIN_LEFT;
			gain_right_q        <= RST_GAIN_RIGHT;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LINE_THRESHOLD:    line_threshold_q    <= cfg_data;
				REG_NEAR_DISTANCE:     near_distance_q     <= cfg_data;
				REG_CRITICAL_DISTANCE: critical_distance_q <= cfg_data;
				REG_CLAP_LOW:          clap_low_q          <= cfg_data;
				REG_CLAP_HIGH:         clap_high_q         <= cfg_data;
				REG_RECOVERY_LENGTH:   recovery_length_q   <= cfg_data[REC_W-1:0];
				REG_GAIN_LEFT:         gain_left_q         <= cfg_data[GAIN_W-1:0];
				REG_GAIN_RIGHT:        gain_right_q        <= cfg_data[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// controller state, decided when the beat is taken; factor_q is updated in ST_MAGL
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			moving_q       <= 1'b0;
			halted_q       <= 1'b0;
			lost_on_left_q <= 1'b0;
			blue_q         <= 1'b0;
			green_q        <= 1'b0;
			recovery_q     <= '0;
			lost_q         <= '0;
			factor_q       <= ONE_Q14;
		end else if (accept) begin
			if (halted_q) begin
			end else if (moving_q && lost_over) begin
				halted_q <= 1'b1;
				blue_q   <= 1'b0;
				green_q  <= 1'b0;
			end else if (!moving_q) begin
				if (clap) moving_q <= 1'b1;
			end else if (lb && rb) begin
				blue_q     <= 1'b1;
				green_q    <= 1'b0;
				recovery_q <= recovery_length_q;
				if (lost_q != LOST_SAT) lost_q <= lost_q + 1'b1;
			end else if (lb || rb) begin
				lost_q <= '0;
				if (recovery_q != '0) begin
					recovery_q <= recovery_q - 1'b1;
				end else begin
					blue_q         <= 1'b0;
					green_q        <= 1'b0;
					lost_on_left_q <= line_left_level < line_right_level;
				end
			end else begin
				recovery_q <= '0;
				lost_q     <= '0;
				blue_q     <= 1'b0;
				green_q    <= 1'b1;
			end
		end else if (state_q == ST_MAGL) begin
			factor_q <= factor_new;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			dist_q     <= front_distance;
			diff_neg_q <= line_left_level < line_right_level;
			absdiff_q  <= (line_left_level < line_right_level)
			              ? line_right_level - line_left_level
			              : line_left_level - line_right_level;
			steer_q    <= 1'b0;
			fwd_l_q    <= 1'b0;
			fwd_r_q    <= 1'b0;
			pwm_l_q    <= '0;
			pwm_r_q    <= '0;
			ml_q       <= FRAC_ONE;
			mr_q       <= FRAC_ONE;
			if (lb && rb) begin
				// spin toward the side the line was last seen
				ml_q <= lost_on_left_q ? FRAC_TURN : FRAC_NEG_ONE;
				mr_q <= lost_on_left_q ? FRAC_NEG_ONE : FRAC_TURN;
			end else if (lb || rb) begin
				if (recovery_q != '0) begin
					ml_q <= lost_on_left_q ? FRAC_TURN : '0;
					mr_q <= lost_on_left_q ? '0 : FRAC_TURN;
				end else begin
					steer_q <= 1'b1;
				end
			end
		end else begin
			unique case (state_q)
				ST_FACT: begin
					if (steer_q) begin
						if (diff_neg_q) mr_q <= steer_clamped;
						else            ml_q <= steer_clamped;
					end
				end
				ST_MAGL: fwd_l_q <= !ml_q[FRAC_W-1] && (ml_q != '0) && (factor_new != '0);
				ST_MAGR: begin
					pwm_l_q <= mul_prod[PWM_W-1:0];
					fwd_r_q <= !mr_q[FRAC_W-1] && (mr_q != '0) && (factor_q != '0);
				end
				ST_LAST: pwm_r_q <= mul_prod[PWM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_fwd_l_q <= fwd_l_q;
			out_pwm_l_q <= pwm_l_q;
			out_fwd_r_q <= fwd_r_q;
			out_pwm_r_q <= pwm_r_q;
			out_blue_q  <= blue_q;
			out_green_q <= green_q;
			out_red_q   <= halted_q;
			out_run_q   <= moving_q;
			out_stop_q  <= halted_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign left_forward  = out_fwd_l_q;
	assign left_pwm      = out_pwm_l_q;
	assign right_forward = out_fwd_r_q;
	assign right_pwm     = out_pwm_r_q;
	assign blue_lamp     = out_blue_q;
	assign green_lamp    = out_green_q;
	assign red_lamp      = out_red_q;
	assign running       = out_run_q;
	assign stopped_lost  = out_stop_q;

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halted state dropped without reset");

	a_halt_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stopped_lost |-> red_lamp && !left_forward && !right_forward
			&& left_pwm == '0 && right_pwm == '0 && !blue_lamp && !green_lamp)
		else $error("halted result drives motors or lamps");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("input taken again while a beat is in work");

	a_factor_range: assert property (@(posedge clk) disable iff (!arst_n)
		factor_q <= ONE_Q14)
		else $error("distance factor above 1.0");

endmodule

`default_nettype wire
